// ===== rtl/lcce_pkg.sv =====
// Shared types and constants for the LED color crossfade engine.
// Depends on nothing; lcce_lane and the engine top level in rtl import it.
package lcce_pkg;

    // Eight color values: primary R,G,B,W then secondary R,G,B,W.
    localparam int NCOL  = 8;
    // The blend lanes cover the eight colors plus the master brightness.
    localparam int NLANE = NCOL + 1;
    localparam int BRIGHT_LANE = NCOL;

    // Smallest fraction step, in Q0.16, that is worth a blend (about 0.004).
    localparam logic signed [16:0] MIN_STEP = 17'sd263;

    // Floor division by 100: multiply by this reciprocal, shift, then correct once.
    localparam logic [10:0] RECIP_100   = 11'd1310;
    localparam int          RECIP_SHIFT = 17;
    localparam logic [6:0]  DIV_100     = 7'd100;

    // Legacy white weights.
    localparam logic [7:0] WHITE_HI_WT  = 8'd155;
    localparam logic [6:0] WHITE_LO_WT  = 7'd100;
    localparam logic [9:0] WHITE_DEN_WT = 10'd765;

    // Configuration register map.
    localparam int APB_AW = 4;
    typedef enum logic [1:0] {
        REG_FADE_TIME   = 2'd0,
        REG_FADE_ENABLE = 2'd1,
        REG_BRIGHT_PCT  = 2'd2,
        REG_LEGACY_WH   = 2'd3
    } reg_idx_t;

    localparam logic [15:0] FADE_TIME_RST  = 16'd700;
    localparam logic        FADE_EN_RST    = 1'b1;
    localparam logic [7:0]  BRIGHT_PCT_RST = 8'd100;
    localparam logic        LEGACY_WH_RST  = 1'b0;

    typedef logic [7:0] chan_t;

endpackage

// ===== rtl/lcce_if.sv =====
// Item channel interfaces for the LED color crossfade engine.
// Holds the input and result channels; no package dependency.
interface lcce_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] prim_red;
    logic [7:0] prim_green;
    logic [7:0] prim_blue;
    logic [7:0] prim_white;
    logic [7:0] sec_red;
    logic [7:0] sec_green;
    logic [7:0] sec_blue;
    logic [7:0] sec_white;
    logic [7:0] target_bright;
    logic [31:0] now_ms;

    modport source (
        output valid, cmd, prim_red, prim_green, prim_blue, prim_white,
               sec_red, sec_green, sec_blue, sec_white, target_bright, now_ms,
        input  ready
    );
    modport sink (
        input  valid, cmd, prim_red, prim_green, prim_blue, prim_white,
               sec_red, sec_green, sec_blue, sec_white, target_bright, now_ms,
        output ready
    );
endinterface

interface lcce_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_prim_red;
    logic [7:0] out_prim_green;
    logic [7:0] out_prim_blue;
    logic [7:0] out_prim_white;
    logic [7:0] out_sec_red;
    logic [7:0] out_sec_green;
    logic [7:0] out_sec_blue;
    logic [7:0] out_sec_white;
    logic [7:0] out_bright;
    logic       fading;

    modport source (
        output valid, out_prim_red, out_prim_green, out_prim_blue, out_prim_white,
               out_sec_red, out_sec_green, out_sec_blue, out_sec_white,
               out_bright, fading,
        input  ready
    );
    modport sink (
        input  valid, out_prim_red, out_prim_green, out_prim_blue, out_prim_white,
               out_sec_red, out_sec_green, out_sec_blue, out_sec_white,
               out_bright, fading,
        output ready
    );
endinterface

// ===== rtl/lcce_div.sv =====
// Restoring divider, one quotient bit per cycle, with a preloaded remainder.
// Standalone; used by the crossfade engine top level.
module lcce_div #(
    parameter int NW = 16,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [DW-1:0] rem_init,
    output logic [NW-1:0] quo,
    output logic          done
);
    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NW-1]};
        diff  = trial - {1'b0, den_reg};
        if (trial >= {1'b0, den_reg})
        begin
            rem_next = diff[DW-1:0];
            quo_next = {quo_reg[NW-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[DW-1:0];
            quo_next = {quo_reg[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;
endmodule

// ===== rtl/lcce_lane.sv =====
// One blend lane: linear interpolation of a value by a Q0.16 fraction.
// Depends on lcce_pkg for the channel type.
module lcce_lane (
    input  lcce_pkg::chan_t from_val,
    input  lcce_pkg::chan_t goal_val,
    input  logic [15:0]     frac,
    output lcce_pkg::chan_t blend_val
);
    import lcce_pkg::*;

    logic signed [8:0]  delta;
    logic signed [25:0] prod;
    logic signed [25:0] acc;

    // from * 65536 + (goal - from) * f never goes negative while f < 1.0.
    always_comb
    begin
        delta     = $signed({1'b0, goal_val}) - $signed({1'b0, from_val});
        prod      = 26'(delta * $signed({1'b0, frac}));
        acc       = $signed({2'b00, from_val, 16'h0000}) + prod;
        blend_val = acc[23:16];
    end
endmodule

// ===== rtl/led_color_crossfade_engine_unit.sv =====
// LED color crossfade engine, top level: register port, sequencer, blend lanes, output merge.
// One item at a time; the next item is taken once the result is staged.
// The 16-step fraction divider and the 26-step white dividers dominate an item's time when they run.
// Reset (rst_n, asynchronous, active low) clears all fade state and loads register defaults.
// Depends on lcce_pkg, lcce_if, lcce_div and lcce_lane.
module led_color_crossfade_engine_unit #(
    parameter int CHANNELS = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcce_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    lcce_in_if.sink                     in_items,
    lcce_out_if.source                  out_items
);
    import lcce_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SET, S_TICK, S_DIV, S_STEP,
        S_POST1, S_POST2, S_POST3, S_WDIV, S_OUT
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [15:0] fade_time_reg;
    logic        fade_en_reg;
    logic [7:0]  pct_reg;
    logic        legacy_reg;

    // Latched input item.
    chan_t       lat_reg [NLANE];
    logic [31:0] lat_now_reg;

    // Fade state; lane BRIGHT_LANE holds the master brightness.
    chan_t       goal_reg [NLANE];
    chan_t       from_reg [NLANE];
    chan_t       now_reg  [NLANE];
    chan_t       appl_reg [NLANE];
    logic        active_reg;
    logic [31:0] start_reg;
    logic [15:0] last_reg;

    // Output computation.
    logic [7:0]  hi_reg  [2];
    logic [7:0]  lo_reg  [2];
    logic [9:0]  sum_reg [2];
    logic [15:0] prod_reg;
    logic [9:0]  q_reg;
    logic [7:0]  obright_reg;

    // Result register.
    logic        out_valid_reg;
    chan_t       out_col_reg [NCOL];
    logic [7:0]  out_bright_reg;
    logic        out_fading_reg;

    // Combinational helpers.
    chan_t       gnew     [NLANE];
    chan_t       lane_res [NLANE];
    logic        changed;
    logic        immediate;
    logic [31:0] elapsed;
    logic        fade_end;
    logic        step_ok;
    logic        accept_in;
    logic        load_out;
    logic        cfg_wr;

    logic        fdiv_start;
    logic [15:0] fquo;
    logic        fdone;

    logic        wdiv_start;
    logic [25:0] wnum  [2];
    logic [17:0] wden  [2];
    logic [25:0] wquo  [2];
    logic        wdone [2];

    logic [26:0] recip_prod;
    logic [16:0] q_times;
    logic [16:0] rem100;
    logic [9:0]  q_fix;
    logic [7:0]  hi_c  [2];
    logic [7:0]  lo_c  [2];

    // ---------------------------------------------------------------
    // Register port. Writes land on the access phase; pready is tied high.
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_FADE_TIME:   prdata = {16'h0000, fade_time_reg};
            REG_FADE_ENABLE: prdata = {31'h0, fade_en_reg};
            REG_BRIGHT_PCT:  prdata = {24'h0, pct_reg};
            REG_LEGACY_WH:   prdata = {31'h0, legacy_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_time_reg <= FADE_TIME_RST;
            fade_en_reg   <= FADE_EN_RST;
            pct_reg       <= BRIGHT_PCT_RST;
            legacy_reg    <= LEGACY_WH_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_FADE_TIME:   fade_time_reg <= pwdata[15:0];
                REG_FADE_ENABLE: fade_en_reg   <= pwdata[0];
                REG_BRIGHT_PCT:  pct_reg       <= pwdata[7:0];
                REG_LEGACY_WH:   legacy_reg    <= pwdata[0];
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Blend lanes. Every color and the brightness run side by side on the
    // same fraction; the sequencer commits them together.
    // ---------------------------------------------------------------
    for (genvar gi = 0; gi < NLANE; gi++)
    begin : g_lane
        lcce_lane u_lane (
            .from_val  (from_reg[gi]),
            .goal_val  (goal_reg[gi]),
            .frac      (fquo),
            .blend_val (lane_res[gi])
        );
    end

    // The fraction divider starts with the elapsed time as its remainder, since
    // elapsed < fade time keeps the quotient below 2^16.
    lcce_div #(.NW(16), .DW(16)) u_fdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (fdiv_start),
        .num      (16'h0000),
        .den      (fade_time_reg),
        .rem_init (elapsed[15:0]),
        .quo      (fquo),
        .done     (fdone)
    );

    // One white divider per color group.
    for (genvar gw = 0; gw < 2; gw++)
    begin : g_white
        lcce_div #(.NW(26), .DW(18)) u_wdiv (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (wdiv_start),
            .num      (wnum[gw]),
            .den      (wden[gw]),
            .rem_init (18'h0),
            .quo      (wquo[gw]),
            .done     (wdone[gw])
        );
    end

    // ---------------------------------------------------------------
    // Combinational decisions.
    // ---------------------------------------------------------------
    always_comb
    begin
        // Unused white slots load as zero when only RGB is present.
        for (int i = 0; i < NCOL; i++)
        begin
            gnew[i] = ((i % 4) < CHANNELS) ? lat_reg[i] : 8'h00;
        end
        gnew[BRIGHT_LANE] = lat_reg[BRIGHT_LANE];

        changed = 1'b0;
        for (int i = 0; i < NLANE; i++)
        begin
            if (gnew[i] != appl_reg[i])
            begin
                changed = 1'b1;
            end
        end
        immediate = !fade_en_reg || (fade_time_reg == 16'h0000);

        elapsed  = lat_now_reg - start_reg;
        fade_end = (elapsed >= {16'h0000, fade_time_reg});
        // A negative difference (time going backwards) also skips the step.
        step_ok  = ($signed({1'b0, fquo}) - $signed({1'b0, last_reg})) >= MIN_STEP;

        for (int g = 0; g < 2; g++)
        begin
            hi_c[g] = now_reg[4*g];
            lo_c[g] = now_reg[4*g];
            for (int k = 1; k < 3; k++)
            begin
                if (now_reg[4*g+k] > hi_c[g])
                begin
                    hi_c[g] = now_reg[4*g+k];
                end
                if (now_reg[4*g+k] < lo_c[g])
                begin
                    lo_c[g] = now_reg[4*g+k];
                end
            end
            wnum[g] = 26'((16'(WHITE_HI_WT * hi_reg[g]) + 16'(WHITE_LO_WT * lo_reg[g]))
                          * sum_reg[g]);
            wden[g] = 18'(WHITE_DEN_WT * hi_reg[g]);
        end

        recip_prod = prod_reg * RECIP_100;
        q_times    = 17'(q_reg * DIV_100);
        rem100     = {1'b0, prod_reg} - q_times;
        q_fix      = q_reg + {9'h000, (rem100 >= {10'h000, DIV_100})};

        accept_in  = in_items.valid && in_items.ready;
        load_out   = (state_reg == S_OUT) && (!out_valid_reg || out_items.ready);
        fdiv_start = (state_reg == S_TICK) && active_reg && !fade_end;
        wdiv_start = (state_reg == S_POST2) && legacy_reg;
    end

    assign in_items.ready = (state_reg == S_IDLE);

    // ---------------------------------------------------------------
    // Sequencer.
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = in_items.cmd ? S_TICK : S_SET;
                end
            end
            S_SET:   state_next = S_POST1;
            S_TICK:  state_next = fdiv_start ? S_DIV : S_POST1;
            S_DIV:
            begin
                if (fdone)
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:  state_next = S_POST1;
            S_POST1: state_next = S_POST2;
            S_POST2: state_next = S_POST3;
            S_POST3: state_next = legacy_reg ? S_WDIV : S_OUT;
            S_WDIV:
            begin
                if (wdone[0] && wdone[1])
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            last_reg      <= '0;
            start_reg     <= '0;
            for (int i = 0; i < NLANE; i++)
            begin
                goal_reg[i] <= '0;
                from_reg[i] <= '0;
                now_reg[i]  <= '0;
                appl_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_items.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_SET:
                begin
                    goal_reg <= gnew;
                    if (changed)
                    begin
                        appl_reg <= gnew;
                        if (immediate)
                        begin
                            from_reg   <= gnew;
                            now_reg    <= gnew;
                            active_reg <= 1'b0;
                            last_reg   <= '0;
                        end
                        else
                        begin
                            // From dark, colors snap and only brightness fades.
                            for (int i = 0; i < NCOL; i++)
                            begin
                                if (now_reg[BRIGHT_LANE] == 8'h00)
                                begin
                                    from_reg[i] <= gnew[i];
                                    now_reg[i]  <= gnew[i];
                                end
                                else if (active_reg)
                                begin
                                    from_reg[i] <= now_reg[i];
                                end
                            end
                            if (active_reg)
                            begin
                                from_reg[BRIGHT_LANE] <= now_reg[BRIGHT_LANE];
                            end
                            last_reg   <= '0;
                            active_reg <= 1'b1;
                            start_reg  <= lat_now_reg;
                        end
                    end
                end
                S_TICK:
                begin
                    if (active_reg && fade_end)
                    begin
                        active_reg <= 1'b0;
                        last_reg   <= '0;
                        from_reg   <= goal_reg;
                        now_reg    <= goal_reg;
                    end
                end
                S_STEP:
                begin
                    if (step_ok)
                    begin
                        last_reg <= fquo;
                        now_reg  <= lane_res;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers: input latch, output arithmetic and result staging.
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            lat_reg[0]  <= in_items.prim_red;
            lat_reg[1]  <= in_items.prim_green;
            lat_reg[2]  <= in_items.prim_blue;
            lat_reg[3]  <= in_items.prim_white;
            lat_reg[4]  <= in_items.sec_red;
            lat_reg[5]  <= in_items.sec_green;
            lat_reg[6]  <= in_items.sec_blue;
            lat_reg[7]  <= in_items.sec_white;
            lat_reg[BRIGHT_LANE] <= in_items.target_bright;
            lat_now_reg <= in_items.now_ms;
        end
        if (state_reg == S_POST1)
        begin
            for (int g = 0; g < 2; g++)
            begin
                hi_reg[g]  <= hi_c[g];
                lo_reg[g]  <= lo_c[g];
                sum_reg[g] <= 10'(now_reg[4*g]) + 10'(now_reg[4*g+1]) + 10'(now_reg[4*g+2]);
            end
            prod_reg <= now_reg[BRIGHT_LANE] * pct_reg;
        end
        if (state_reg == S_POST2)
        begin
            q_reg <= recip_prod[RECIP_SHIFT+9:RECIP_SHIFT];
        end
        if (state_reg == S_POST3)
        begin
            obright_reg <= (q_fix > 10'd255) ? 8'hFF : q_fix[7:0];
        end
        // Merge stage: colors, derived whites, brightness and the fade flag.
        if (load_out)
        begin
            for (int i = 0; i < NCOL; i++)
            begin
                out_col_reg[i] <= now_reg[i];
            end
            for (int g = 0; g < 2; g++)
            begin
                if (legacy_reg && (hi_reg[g] != 8'h00))
                begin
                    out_col_reg[4*g+3] <= wquo[g][7:0];
                end
            end
            out_bright_reg <= obright_reg;
            out_fading_reg <= active_reg;
        end
    end

    assign out_items.valid          = out_valid_reg;
    assign out_items.out_prim_red   = out_col_reg[0];
    assign out_items.out_prim_green = out_col_reg[1];
    assign out_items.out_prim_blue  = out_col_reg[2];
    assign out_items.out_prim_white = out_col_reg[3];
    assign out_items.out_sec_red    = out_col_reg[4];
    assign out_items.out_sec_green  = out_col_reg[5];
    assign out_items.out_sec_blue   = out_col_reg[6];
    assign out_items.out_sec_white  = out_col_reg[7];
    assign out_items.out_bright     = out_bright_reg;
    assign out_items.fading         = out_fading_reg;
endmodule

// ===== bench/lcce_checker.sv =====
// Checker for the LED color crossfade engine: watches the item channels and the register port.
// Predicts every result from its own copy of the fade state; depends on lcce_pkg and lcce_if.
module lcce_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [3:0] paddr,
    input  logic [31:0] pwdata,
    input  logic       pready,
    lcce_in_if.sink    in_mon,
    lcce_out_if.sink   out_mon,
    output int         fail_count,
    output int         pending
);
    import lcce_pkg::*;

    typedef struct packed {
        logic [7:0][7:0] colors;
        logic [7:0]      bright;
        logic            fading;
    } shown_t;

    logic [15:0] fade_ms;
    logic        fade_on;
    logic [7:0]  pct;
    logic        wh_mode;

    logic [7:0] goal_c [8];
    logic [7:0] from_c [8];
    logic [7:0] cur_c [8];
    logic [7:0] appl_c [8];
    logic [7:0] goal_b, from_b, cur_b, appl_b;
    logic       running;
    logic [31:0] start_ms;
    logic [15:0] prev_frac;

    shown_t expected_q[$];

    function automatic logic [7:0] mix(logic [7:0] a, logic [7:0] b, logic [31:0] f);
        longint acc;
        acc = longint'(a) * 65536 + (longint'(b) - longint'(a)) * longint'(f);
        if (acc < 0)
            acc = 0;
        return acc[23:16];
    endfunction

    function automatic logic [7:0] white_of(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           logic [7:0] w);
        int unsigned hi;
        int unsigned lo;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        if (hi == 0)
            return w;
        return 8'(((155 * hi + 100 * lo) * (r + g + b)) / (765 * hi));
    endfunction

    task automatic snap_colors();
        for (int i = 0; i < 8; i++)
        begin
            from_c[i] = goal_c[i];
            cur_c[i] = goal_c[i];
        end
    endtask

    task automatic predict_item();
        logic [7:0] v [8];
        logic        diff;
        logic [31:0] el;
        logic [31:0] f;
        int unsigned br;
        shown_t s;
        v = '{in_mon.prim_red, in_mon.prim_green, in_mon.prim_blue, in_mon.prim_white,
              in_mon.sec_red, in_mon.sec_green, in_mon.sec_blue, in_mon.sec_white};
        if (in_mon.cmd)
        begin
            if (running)
            begin
                el = in_mon.now_ms - start_ms;
                if (el >= fade_ms)
                begin
                    running = 1'b0;
                    prev_frac = '0;
                    snap_colors();
                    from_b = goal_b;
                    cur_b = goal_b;
                end
                else
                begin
                    f = {el[15:0], 16'h0} / fade_ms;
                    if (int'(f) - int'(prev_frac) >= int'(MIN_STEP))
                    begin
                        prev_frac = f[15:0];
                        for (int i = 0; i < 8; i++)
                            cur_c[i] = mix(from_c[i], goal_c[i], f);
                        cur_b = mix(from_b, goal_b, f);
                    end
                end
            end
        end
        else
        begin
            diff = 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                goal_c[i] = v[i];
                if (goal_c[i] != appl_c[i])
                    diff = 1'b1;
            end
            goal_b = in_mon.target_bright;
            if (goal_b != appl_b)
                diff = 1'b1;
            if (diff)
            begin
                appl_c = goal_c;
                if (cur_b == 0)
                    snap_colors();
                appl_b = goal_b;
                if (!fade_on || fade_ms == 0)
                begin
                    snap_colors();
                    from_b = goal_b;
                    cur_b = goal_b;
                    running = 1'b0;
                    prev_frac = '0;
                end
                else
                begin
                    if (running)
                    begin
                        from_c = cur_c;
                        from_b = cur_b;
                    end
                    prev_frac = '0;
                    running = 1'b1;
                    start_ms = in_mon.now_ms;
                end
            end
        end
        for (int i = 0; i < 8; i++)
            s.colors[i] = cur_c[i];
        if (wh_mode)
        begin
            s.colors[3] = white_of(cur_c[0], cur_c[1], cur_c[2], cur_c[3]);
            s.colors[7] = white_of(cur_c[4], cur_c[5], cur_c[6], cur_c[7]);
        end
        br = (int'(cur_b) * int'(pct)) / 100;
        s.bright = (br > 255) ? 8'hFF : 8'(br);
        s.fading = running;
        expected_q.push_back(s);
    endtask

    task automatic compare_result();
        shown_t e;
        shown_t a;
        a.colors = {out_mon.out_sec_white, out_mon.out_sec_blue, out_mon.out_sec_green,
                    out_mon.out_sec_red, out_mon.out_prim_white, out_mon.out_prim_blue,
                    out_mon.out_prim_green, out_mon.out_prim_red};
        a.bright = out_mon.out_bright;
        a.fading = out_mon.fading;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result %h", $time, a);
            fail_count++;
            return;
        end
        e = expected_q.pop_front();
        for (int i = 0; i < 8; i++)
            if (e.colors[i] != a.colors[i])
            begin
                $display("%0t: color %0d expected %0d actual %0d", $time, i,
                         e.colors[i], a.colors[i]);
                fail_count++;
            end
        if (e.bright != a.bright)
        begin
            $display("%0t: brightness expected %0d actual %0d", $time, e.bright, a.bright);
            fail_count++;
        end
        if (e.fading != a.fading)
        begin
            $display("%0t: fading expected %0b actual %0b", $time, e.fading, a.fading);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_ms = FADE_TIME_RST;
            fade_on = FADE_EN_RST;
            pct = BRIGHT_PCT_RST;
            wh_mode = LEGACY_WH_RST;
            for (int i = 0; i < 8; i++)
            begin
                goal_c[i] = '0;
                from_c[i] = '0;
                cur_c[i] = '0;
                appl_c[i] = '0;
            end
            {goal_b, from_b, cur_b, appl_b} = '0;
            running = 1'b0;
            start_ms = '0;
            prev_frac = '0;
            fail_count = 0;
            expected_q.delete();
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
                compare_result();
            if (in_mon.valid && in_mon.ready)
                predict_item();
            if (psel && penable && pwrite && pready)
                case (reg_idx_t'(paddr[3:2]))
                    REG_FADE_TIME:   fade_ms = pwdata[15:0];
                    REG_FADE_ENABLE: fade_on = pwdata[0];
                    REG_BRIGHT_PCT:  pct = pwdata[7:0];
                    REG_LEGACY_WH:   wh_mode = pwdata[0];
                    default: ;
                endcase
        end
        pending = expected_q.size();
    end
endmodule

// ===== bench/led_color_crossfade_engine_unit_tb.sv =====
// Testbench top for the LED color crossfade engine: clock, reset, stimulus and verdict.
// Drives the register port and the input channel; the lcce_checker module does all checking.
// Depends on lcce_pkg, lcce_if, the block itself and lcce_checker.
module led_color_crossfade_engine_unit_tb;
    import lcce_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    // The result side stalls in bursts; quiet_sink turns that off for the last part,
    // and hold_off_cycles forces one long stall so the block backs up.
    logic        quiet_sink = 1'b0;
    int          hold_off_cycles = 0;
    logic        quiet_source = 1'b0;

    // Running millisecond clock that tick items carry.
    logic [31:0] clock_ms;

    lcce_in_if  in_items ();
    lcce_out_if out_items ();

    led_color_crossfade_engine_unit uut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_items(in_items.sink), .out_items(out_items.source)
    );

    lcce_checker checker_i (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .in_mon(in_items.sink), .out_mon(out_items.sink),
        .fail_count(fail_count), .pending(pending)
    );

    always #2 clk = ~clk;

    // Result-side ready: random stall bursts, one forced long stall.
    initial
    begin
        out_items.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                out_items.ready <= 1'b0;
                hold_off_cycles--;
            end
            else if (!quiet_sink && $urandom_range(0, 7) == 0)
            begin
                out_items.ready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge clk);
            end
            else
                out_items.ready <= 1'b1;
        end
    end

    // Writes one register through a setup phase and an access phase, then closes the transfer.
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Waits until every predicted result has come back, then lets the block settle
    // for the worst latency (tick with legacy white) before any register write.
    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    // Offers one item and holds it until accepted. Sender gaps come as random bursts.
    // Without a gap, an item goes out while the block is still busy with the previous
    // one, so this costs no throughput.
    task automatic send_item(logic cmd, logic [7:0] c [8], logic [7:0] br, logic [31:0] ms);
        @(negedge clk);
        if (!quiet_source && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 11)) @(negedge clk);
        in_items.valid <= 1'b1;
        in_items.cmd <= cmd;
        in_items.prim_red <= c[0];
        in_items.prim_green <= c[1];
        in_items.prim_blue <= c[2];
        in_items.prim_white <= c[3];
        in_items.sec_red <= c[4];
        in_items.sec_green <= c[5];
        in_items.sec_blue <= c[6];
        in_items.sec_white <= c[7];
        in_items.target_bright <= br;
        in_items.now_ms <= ms;
        @(posedge clk);
        while (!in_items.ready)
            @(posedge clk);
        @(negedge clk);
        in_items.valid <= 1'b0;
    endtask

    // A set-target item with random colors; narrow picks a small set of values so
    // that repeats of the applied target happen often.
    task automatic send_target(bit narrow, logic [31:0] ms);
        logic [7:0] c [8];
        logic [7:0] br;
        for (int i = 0; i < 8; i++)
            c[i] = narrow ? 8'($urandom_range(0, 1) * 255) : 8'($urandom);
        br = narrow ? 8'($urandom_range(0, 1) * 255) : 8'($urandom);
        if ($urandom_range(0, 9) == 0)
            br = 8'd0;
        send_item(1'b0, c, br, ms);
    endtask

    task automatic send_tick(logic [31:0] ms);
        logic [7:0] c [8];
        for (int i = 0; i < 8; i++)
            c[i] = 8'($urandom);
        send_item(1'b1, c, 8'($urandom), ms);
    endtask

    // One fade sequence: a new target, then ticks that walk time forward in steps
    // scaled to the fade length, often past its end, with the odd backwards step and retarget.
    task automatic fade_sequence(int unsigned span);
        int unsigned n;
        send_target($urandom_range(0, 3) == 0, clock_ms);
        n = $urandom_range(3, 12);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                clock_ms = clock_ms - $urandom_range(0, span / 4 + 1);
            else
                clock_ms = clock_ms + $urandom_range(0, span / 4 + 2);
            if ($urandom_range(0, 7) == 0)
                send_target(1'b0, clock_ms);
            else
                send_tick(clock_ms);
        end
    endtask

    initial
    begin
        logic [7:0] c [8];
        int unsigned span;
        in_items.valid = 1'b0;
        in_items.cmd = 1'b0;
        in_items.prim_red = '0;
        in_items.prim_green = '0;
        in_items.prim_blue = '0;
        in_items.prim_white = '0;
        in_items.sec_red = '0;
        in_items.sec_green = '0;
        in_items.sec_blue = '0;
        in_items.sec_white = '0;
        in_items.target_bright = '0;
        in_items.now_ms = '0;
        clock_ms = 32'hFFFF_FF00;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, reset settings: tick while idle, a first target from zero
        // brightness (colors snap), ticks through the fade across the 32-bit wrap,
        // a retarget mid-fade, time going backwards, an unchanged target.
        for (int i = 0; i < 8; i++)
            c[i] = 8'hFF;
        send_tick(32'h0);
        send_item(1'b0, c, 8'hFF, clock_ms);
        send_tick(clock_ms + 1);
        send_tick(clock_ms + 350);
        send_tick(clock_ms + 352);
        for (int i = 0; i < 8; i++)
            c[i] = 8'h00;
        send_item(1'b0, c, 8'h00, clock_ms + 400);
        send_tick(clock_ms + 300);
        send_tick(clock_ms + 700);
        send_tick(clock_ms + 1100);
        send_tick(clock_ms + 1101);
        send_item(1'b0, c, 8'h00, clock_ms + 1200);
        for (int i = 0; i < 8; i++)
            c[i] = 8'(i * 37);
        send_item(1'b0, c, 8'h80, 32'hFFFF_FFFF);
        send_tick(32'h0000_0100);
        send_tick(32'h0000_0400);
        drain();

        // Extremes of the registers: legacy white, percent 255 and 0, fade time zero and
        // the largest one, fading off.
        write_reg(REG_LEGACY_WH, 32'd1);
        write_reg(REG_BRIGHT_PCT, 32'd255);
        write_reg(REG_FADE_TIME, 32'd0);
        send_item(1'b0, c, 8'hFF, 32'h0);
        c[0] = 8'd0; c[1] = 8'd0; c[2] = 8'd0; c[4] = 8'hFF; c[5] = 8'd1; c[6] = 8'd0;
        send_item(1'b0, c, 8'h01, 32'h0);
        drain();
        write_reg(REG_FADE_TIME, 32'hFFFF);
        write_reg(REG_BRIGHT_PCT, 32'd0);
        send_target(1'b0, 32'h8000_0000);
        send_tick(32'h8000_7FFF);
        drain();
        // Fade time dropped to zero during a running fade: the next tick ends it.
        write_reg(REG_FADE_TIME, 32'd0);
        send_tick(32'h8000_8000);
        drain();
        write_reg(REG_FADE_ENABLE, 32'd0);
        write_reg(REG_FADE_TIME, 32'd700);
        send_target(1'b0, 32'h0);
        send_tick(32'h10);
        drain();

        // Random phases, each with its own register setting. Most stimulus is
        // fade sequences with random content; some is loose noise.
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0: span = 1;
                1: span = 65535;
                default: span = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                          : $urandom_range(1, 2000);
            endcase
            write_reg(REG_FADE_TIME, span);
            write_reg(REG_FADE_ENABLE, phase == 4 ? 0 : 1);
            write_reg(REG_BRIGHT_PCT, phase == 0 ? 255 : (phase == 1 ? 0 : $urandom_range(0, 255)));
            write_reg(REG_LEGACY_WH, $urandom_range(0, 1));
            if (phase == 9)
            begin
                quiet_source = 1'b1;
                quiet_sink = 1'b1;
            end
            for (int s = 0; s < 26; s++)
            begin
                if (phase == 3 && s == 5)
                begin
                    // Long receiver stall while items keep being offered.
                    hold_off_cycles = 300;
                end
                if (phase == 5 && s == 10)
                begin
                    // Sender waits for every outstanding result.
                    while (pending != 0)
                        @(negedge clk);
                end
                if ($urandom_range(0, 4) == 0)
                    send_tick($urandom);
                else
                    fade_sequence(span == 0 ? 1 : span);
            end
            drain();
        end

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
